// ----- hdl/mtg_pkg.sv -----
// Shared types, constants and functions of the MT19937 random generator.
// Used by the controller, the datapath and the top level.
package mtg_pkg;

	localparam int STATE_WORDS = 624;
	localparam int MID_OFFSET  = 397;
	localparam int POS_W       = 10;
	localparam int WORD_W      = 32;

	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(STATE_WORDS - 1);
	localparam logic [POS_W-1:0] FAR_SPLIT = POS_W'(STATE_WORDS - MID_OFFSET);
	localparam logic [POS_W-1:0] FAR_ADD   = POS_W'(MID_OFFSET);

	localparam logic [31:0] MAT_A        = 32'h9908B0DF;
	localparam logic [31:0] SEED_MUL     = 32'h6C078965;
	localparam logic [31:0] TMASK_B      = 32'h9D2C5680;
	localparam logic [31:0] TMASK_C      = 32'hEFC60000;
	localparam logic [31:0] HI_BIT       = 32'h80000000;
	localparam logic [31:0] LO_BITS      = 32'h7FFFFFFF;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;
	localparam logic [31:0] ALL_ONES     = 32'hFFFFFFFF;

	typedef enum logic [1:0] {
		RD_POS = 2'd0,
		RD_NXT = 2'd1,
		RD_FAR = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic    seed_init;
		logic    seed_mul;
		logic    seed_add;
		logic    load_mod;
		logic    div_lim;
		logic    set_limit;
		rd_sel_t rd_sel;
		logic    latch_a;
		logic    latch_b;
		logic    twist_wr;
		logic    temper;
		logic    div_rem;
		logic    raw_take;
		logic    rem_take;
		logic    deliver;
	} cmd_t;

	typedef struct packed {
		logic seed_last;
		logic mod_zero;
		logic reject;
		logic div_busy;
		logic out_free;
	} status_t;

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TMASK_B);
		y = y ^ ((y << 15) & TMASK_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [31:0] twist(input logic [31:0] cur, input logic [31:0] nxt,
		input logic [31:0] far);
		logic [31:0] y;
		logic [31:0] t;
		y = (cur & HI_BIT) | (nxt & LO_BITS);
		t = y >> 1;
		if (y[0]) begin
			t = t ^ MAT_A;
		end
		return far ^ t;
	endfunction

endpackage

// ----- hdl/mt19937_random_generator.sv -----
// MT19937 random generator, top level: ties controller and datapath.
// Depends on mtg_pkg, mtg_ctrl, mtg_dp.
//
// Usage: each beat on the request channel (in_valid/in_ready) carries a
// modulus. Zero asks for one raw tempered 32-bit word; a nonzero value asks
// for an unbiased residue below it. Each request yields one beat on the
// result channel (out_valid/out_ready) carrying random_value.
// Each state word is twisted lazily when it is read: three reads of the
// state RAM (one write port, one read port) and one write per word drawn.
// A raw request runs through the read, twist and tempering states to the
// result register. A nonzero modulus first runs the bit-serial remainder
// unit for the limit and later again for the final remainder, and each
// rejected draw repeats the reads and the twist.
// After reset, and after every write on cfg_we/cfg_wdata, the state array
// is refilled by the seeding recurrence, a multiply and an add step per
// word, during which in_ready stays low. Reset seeds with 5489.
// A finished result waits in the output register while the receiver
// stalls; the next request is accepted meanwhile, and its result waits
// until the register is free.
module mt19937_random_generator
	import mtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] modulus,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] random_value
);

	cmd_t    cmd;
	status_t status;

	mtg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	mtg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.modulus     (modulus),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.random_value(random_value)
	);

endmodule

// ----- hdl/mtg_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/mtg_div.sv -----
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on mtg_pkg.
module mtg_div
	import mtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] remainder
);

	logic [5:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= diff[32] ? trial[31:0] : diff[31:0];
		end
	end

	assign busy      = (cnt_q != '0);
	assign remainder = rem_q;

endmodule

// ----- hdl/mtg_ctrl.sv -----
// Controller state machine of the MT19937 generator: seeding sweep,
// per-word twist sequence, rejection loop and result hand-off. Depends on mtg_pkg.
module mtg_ctrl
	import mtg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [13:0] {
		S_SEED0 = 14'b00000000000001,
		S_SMUL  = 14'b00000000000010,
		S_SADD  = 14'b00000000000100,
		S_IDLE  = 14'b00000000001000,
		S_PREP  = 14'b00000000010000,
		S_LIM   = 14'b00000000100000,
		S_RD0   = 14'b00000001000000,
		S_RD1   = 14'b00000010000000,
		S_RD2   = 14'b00000100000000,
		S_RD3   = 14'b00001000000000,
		S_TEMP  = 14'b00010000000000,
		S_CHK   = 14'b00100000000000,
		S_REM   = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rd_sel = RD_POS;
		unique case (state_q)
			S_SEED0: begin
				cmd.seed_init = 1'b1;
				state_d = S_SMUL;
			end
			S_SMUL: begin
				cmd.seed_mul = 1'b1;
				state_d = S_SADD;
			end
			S_SADD: begin
				cmd.seed_add = 1'b1;
				state_d = status.seed_last ? S_IDLE : S_SMUL;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_mod = 1'b1;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (status.mod_zero) begin
					state_d = S_RD0;
				end else begin
					cmd.div_lim = 1'b1;
					state_d = S_LIM;
				end
			end
			S_LIM: begin
				if (!status.div_busy) begin
					cmd.set_limit = 1'b1;
					state_d = S_RD0;
				end
			end
			S_RD0: begin
				state_d = S_RD1;
			end
			S_RD1: begin
				cmd.rd_sel  = RD_NXT;
				cmd.latch_a = 1'b1;
				state_d = S_RD2;
			end
			S_RD2: begin
				cmd.rd_sel  = RD_FAR;
				cmd.latch_b = 1'b1;
				state_d = S_RD3;
			end
			S_RD3: begin
				cmd.twist_wr = 1'b1;
				state_d = S_TEMP;
			end
			S_TEMP: begin
				cmd.temper = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (status.mod_zero) begin
					cmd.raw_take = 1'b1;
					state_d = S_OUT;
				end else if (status.reject) begin
					state_d = S_RD0;
				end else begin
					cmd.div_rem = 1'b1;
					state_d = S_REM;
				end
			end
			S_REM: begin
				if (!status.div_busy) begin
					cmd.rem_take = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				cmd.deliver = 1'b1;
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_SEED0;
			end
		endcase
		// A new seed restarts the seeding sweep from any state.
		if (cfg_we) begin
			state_d = S_SEED0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SEED0;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// ----- hdl/mtg_dp.sv -----
// Datapath of the MT19937 generator: state RAM, seeding multiplier, twist,
// tempering, remainder unit and output register. Depends on mtg_pkg, mtg_ram, mtg_div.
module mtg_dp
	import mtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic [31:0] modulus,
	input  cmd_t        cmd,
	output status_t     status,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] random_value
);

	logic [31:0]      seed_q;
	logic [31:0]      prev_q;
	logic [31:0]      prod_q;
	logic [POS_W-1:0] idx_q;
	logic [POS_W-1:0] pos_q;
	logic [31:0]      mod_q;
	logic [31:0]      limit_q;
	logic [31:0]      a_q;
	logic [31:0]      b_q;
	logic [31:0]      tw_q;
	logic [31:0]      draw_q;
	logic [31:0]      res_q;
	logic             out_valid_q;
	logic [31:0]      out_q;

	logic [POS_W-1:0] nxt_pos;
	logic [POS_W-1:0] far_pos;
	logic [POS_W-1:0] raddr;
	logic [31:0]      rdata;
	logic             we;
	logic [POS_W-1:0] waddr;
	logic [31:0]      wdata;
	logic [31:0]      seed_word;
	logic [31:0]      new_word;
	logic             div_busy;
	logic [31:0]      div_rem;
	logic             out_free;

	assign nxt_pos = (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
	assign far_pos = (pos_q < FAR_SPLIT) ? pos_q + FAR_ADD : pos_q - FAR_SPLIT;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_NXT:  raddr = nxt_pos;
			RD_FAR:  raddr = far_pos;
			default: raddr = pos_q;
		endcase
	end

	assign seed_word = prod_q + {{(32-POS_W){1'b0}}, idx_q};
	assign new_word  = twist(a_q, b_q, rdata);

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = new_word;
		priority if (cmd.seed_init) begin
			we    = 1'b1;
			waddr = '0;
			wdata = seed_q;
		end else if (cmd.seed_add) begin
			we    = 1'b1;
			waddr = idx_q;
			wdata = seed_word;
		end else if (cmd.twist_wr) begin
			we = 1'b1;
		end
	end

	mtg_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STATE_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	mtg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_lim | cmd.div_rem),
		.dividend (cmd.div_rem ? draw_q : ALL_ONES),
		.divisor  (mod_q),
		.busy     (div_busy),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= DEFAULT_SEED;
			pos_q  <= '0;
			idx_q  <= '0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			// The lazy twist restarts at word zero after every reseed.
			if (cmd.seed_init) begin
				pos_q <= '0;
				idx_q <= POS_W'(1);
			end else if (cmd.seed_add) begin
				idx_q <= idx_q + POS_W'(1);
			end
			if (cmd.temper) begin
				pos_q <= nxt_pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.seed_init) begin
			prev_q <= seed_q;
		end else if (cmd.seed_add) begin
			prev_q <= seed_word;
		end
		if (cmd.seed_mul) begin
			prod_q <= SEED_MUL * (prev_q ^ (prev_q >> 30));
		end
		if (cmd.load_mod) begin
			mod_q <= modulus;
		end
		if (cmd.set_limit) begin
			limit_q <= ALL_ONES - div_rem;
		end
		if (cmd.latch_a) begin
			a_q <= rdata;
		end
		if (cmd.latch_b) begin
			b_q <= rdata;
		end
		if (cmd.twist_wr) begin
			tw_q <= new_word;
		end
		if (cmd.temper) begin
			draw_q <= temper(tw_q);
		end
		if (cmd.raw_take) begin
			res_q <= draw_q;
		end else if (cmd.rem_take) begin
			res_q <= div_rem;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver && out_free) begin
			out_q <= res_q;
		end
	end

	assign status.seed_last = (idx_q == LAST_POS);
	assign status.mod_zero  = (mod_q == '0);
	assign status.reject    = (draw_q >= limit_q);
	assign status.div_busy  = div_busy;
	assign status.out_free  = out_free;

	assign out_valid    = out_valid_q;
	assign random_value = out_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("read position left the state array");
	a_div_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_lim || cmd.div_rem) |=> div_busy)
		else $error("remainder unit did not start");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rem_take |=> (res_q < mod_q))
		else $error("residue not below modulus");
	a_accept_draw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_rem |-> (draw_q < limit_q))
		else $error("rejected draw was reduced");

endmodule

// ----- tb/mtg_checker.sv -----
// Checker for the MT19937 generator: watches both channels, predicts each
// result from its own copy of the state array and counts mismatches.
`timescale 1ns / 1ps

module mtg_checker
	import mtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] modulus,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] random_value,
	output int          fail_count,
	output int          pending
);

	logic [31:0] words [STATE_WORDS];
	int unsigned pos;
	logic [31:0] expected_values [$];

	function automatic void reseed_words(input logic [31:0] s);
		logic [31:0] p;
		words[0] = s;
		for (int k = 1; k < STATE_WORDS; k++) begin
			p = words[k-1];
			words[k] = SEED_MUL * (p ^ (p >> 30)) + 32'(k);
		end
		pos = STATE_WORDS;
	endfunction

	function automatic void regenerate();
		logic [31:0] y;
		logic [31:0] t;
		for (int k = 0; k < STATE_WORDS; k++) begin
			y = (words[k] & HI_BIT) | (words[(k+1) % STATE_WORDS] & LO_BITS);
			t = y >> 1;
			if (y[0]) begin
				t = t ^ MAT_A;
			end
			words[k] = words[(k + MID_OFFSET) % STATE_WORDS] ^ t;
		end
		pos = 0;
	endfunction

	function automatic logic [31:0] draw_tempered();
		logic [31:0] y;
		if (pos >= STATE_WORDS) begin
			regenerate();
		end
		y = words[pos];
		pos++;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TMASK_B);
		y = y ^ ((y << 15) & TMASK_C);
		return y ^ (y >> 18);
	endfunction

	function automatic logic [31:0] predict_value(input logic [31:0] m);
		logic [31:0] lim;
		logic [31:0] r;
		if (m == 0) begin
			return draw_tempered();
		end
		lim = ALL_ONES - (ALL_ONES % m);
		do begin
			r = draw_tempered();
		end while (r >= lim);
		return r % m;
	endfunction

	assign pending = expected_values.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reseed_words(DEFAULT_SEED);
			expected_values.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				reseed_words(cfg_wdata);
			end
			if (in_valid && in_ready) begin
				expected_values.push_back(predict_value(modulus));
			end
			if (out_valid && out_ready) begin
				if (expected_values.size() == 0) begin
					$error("unexpected result beat random_value=%h", random_value);
					fail_count <= fail_count + 1;
				end else if (expected_values[0] !== random_value) begin
					$error("random_value: expected %h, actual %h", expected_values[0],
						random_value);
					fail_count <= fail_count + 1;
					void'(expected_values.pop_front());
				end else begin
					void'(expected_values.pop_front());
				end
			end
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Top of the MT19937 generator testbench: clock, reset, seeds, requests
// and verdict. Depends on mtg_pkg, mt19937_random_generator and mtg_checker.
`timescale 1ns / 1ps

module tb_top
	import mtg_pkg::*;
;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [31:0] cfg_wdata = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [31:0] modulus = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [31:0] random_value;
	int          fail_count;
	int          pending;
	int          src_idle_pct = 0;
	int          snk_idle_pct = 0;
	bit          snk_hold = 0;
	int          idle_cycles = 0;

	always #6 clk = ~clk;

	mt19937_random_generator uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .modulus(modulus),
		.out_valid(out_valid), .out_ready(out_ready), .random_value(random_value)
	);

	mtg_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .modulus(modulus),
		.out_valid(out_valid), .out_ready(out_ready), .random_value(random_value),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		if (snk_hold) begin
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Watchdog: cycles without any accepted beat, reseeding included.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Valid stays high after an accepted beat; the caller drops it once the
	// last request of a sequence has gone.
	task automatic send_request(input logic [31:0] m);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		modulus <= m;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	task automatic drain_results();
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] s);
		cfg_we <= 1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [31:0] pick_modulus();
		case ($urandom_range(5))
			0: return 0;
			1: return $urandom_range(1, 16);
			2: return $urandom_range(17, 100000);
			3: return 32'h80000000 + $urandom_range(0, 32'h3FFFFFFF);
			4: return ~$urandom_range(0, 255);
			default: return $urandom();
		endcase
	endfunction

	task automatic random_phase(input int count, input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		repeat (count) send_request(pick_modulus());
		in_valid <= 0;
	endtask

	initial begin
		logic [31:0] directed [] = '{0, 1, 2, 3, 32'hFFFFFFFF, 32'hFFFFFFFE,
			32'h80000000, 32'h80000001, 32'h7FFFFFFF, 32'hAAAAAAAA, 32'h55555555,
			10, 0, 6, 32'hC0000000, 32'h40000001};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) send_request(directed[i]);
		in_valid <= 0;
		drain_results();

		write_seed(0);
		repeat (12) send_request(0);
		in_valid <= 0;
		drain_results();
		write_seed(32'hFFFFFFFF);
		random_phase(160, 9, 77);
		drain_results();

		// Receiver holds off while requests keep coming, so the block stalls.
		write_seed($urandom());
		snk_hold = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				snk_hold = 0;
			end
			begin
				repeat (6) send_request($urandom_range(0, 1) ? 0 : $urandom());
				in_valid <= 0;
			end
		join
		drain_results();

		write_seed(DEFAULT_SEED);
		random_phase(160, 77, 9);
		drain_results();
		write_seed($urandom());
		random_phase(160, 0, 0);
		drain_results();

		if (fail_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/mtg_pkg.sv
hdl/mtg_ram.sv
hdl/mtg_div.sv
hdl/mtg_ctrl.sv
hdl/mtg_dp.sv
hdl/mt19937_random_generator.sv
tb/mtg_checker.sv
tb/tb_top.sv
